// ===== rtl/wstd_pkg.sv =====
// shared types and constants for the task dispatcher
package wstd_pkg;

  localparam int MaxWorkers  = 8;
  localparam int DequeDepth  = 256;
  localparam int SharedDepth = 256;
  localparam int WBits       = $clog2(MaxWorkers);
  localparam int DBits       = $clog2(DequeDepth);
  localparam int PBits       = DBits + 1;
  localparam int SBits       = $clog2(SharedDepth);
  localparam int CBits       = SBits + 1;

  localparam logic [1:0] FUNC_ENQ   = 2'd0;
  localparam logic [1:0] FUNC_SPAWN = 2'd1;
  localparam logic [1:0] FUNC_GET   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  localparam logic [1:0] SRC_OWN    = 2'd0;
  localparam logic [1:0] SRC_SHARED = 2'd1;
  localparam logic [1:0] SRC_STOLEN = 2'd2;
  localparam logic [1:0] SRC_NONE   = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  worker;
    logic [31:0] job_token;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  source;
    logic [2:0]  victim;
    logic [31:0] job_out;
    logic [31:0] job_number;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_PUSH_DEQ = 3'b001,
    OP_PUSH_SH  = 3'b010,
    OP_GET      = 3'b100
  } op_t;

  // classified command handed from front to back
  typedef struct packed {
    op_t         op;
    logic        answer_only;
    logic [1:0]  status;
    logic [WBits-1:0] worker;
    logic [WBits:0]   nwork;
    logic [31:0] token;
  } cmd_t;

endpackage

// ===== rtl/wstd_front.sv =====
// front: accepts input beats, classifies them and queues commands
module wstd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  wstd_pkg::in_item_t  in_data,
  output logic                cmd_valid,
  input  logic                cmd_take,
  output wstd_pkg::cmd_t      cmd
);

  logic [3:0] active_workers;
  wstd_pkg::cmd_t q [2];
  logic [1:0] cnt;
  logic rd_ptr, wr_ptr;
  logic [wstd_pkg::WBits:0] n;
  wstd_pkg::cmd_t c;
  logic push, pop;

  always_comb begin
    if (active_workers == 4'd0) n = (wstd_pkg::WBits+1)'(1);
    else if (32'(active_workers) > wstd_pkg::MaxWorkers)
      n = (wstd_pkg::WBits+1)'(wstd_pkg::MaxWorkers);
    else n = (wstd_pkg::WBits+1)'(active_workers);
  end

  always_comb begin
    c = '0;
    c.token  = in_data.job_token;
    c.worker = in_data.worker[wstd_pkg::WBits-1:0];
    c.nwork  = n;
    c.status = wstd_pkg::ST_EMPTY;
    c.op     = wstd_pkg::OP_GET;
    if (in_data.func == wstd_pkg::FUNC_SPAWN && 32'(in_data.worker) < 32'(n)) begin
      c.op = wstd_pkg::OP_PUSH_DEQ;
    end else if (in_data.func == wstd_pkg::FUNC_ENQ || in_data.func == wstd_pkg::FUNC_SPAWN) begin
      c.op = wstd_pkg::OP_PUSH_SH;
    end else if (in_data.func == wstd_pkg::FUNC_GET) begin
      if (32'(in_data.worker) >= 32'(n)) begin
        c.answer_only = 1'b1;
        c.status = wstd_pkg::ST_BAD;
      end
    end else begin
      c.answer_only = 1'b1;
    end
  end

  assign in_stall  = (cnt == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt != 2'd0);
  assign pop       = cmd_valid && cmd_take;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      active_workers <= 4'd1;
      cnt <= '0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (cfg_we) active_workers <= cfg_data;
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= c;
  end

endmodule

// ===== rtl/wstd_back.sv =====
// back: executes commands on the deques and shared stack
module wstd_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_take,
  input  wstd_pkg::cmd_t      cmd,
  output logic                out_valid,
  input  logic                out_stall,
  output wstd_pkg::out_item_t out_data
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_READ  = 5'b00100,
    S_DATA  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state;
  wstd_pkg::cmd_t cur;
  logic [wstd_pkg::PBits-1:0] top [wstd_pkg::MaxWorkers];
  logic [wstd_pkg::PBits-1:0] bot [wstd_pkg::MaxWorkers];
  logic [wstd_pkg::CBits-1:0] shared_count;
  logic [31:0] next_number;
  logic [31:0] deque_mem [wstd_pkg::MaxWorkers*wstd_pkg::DequeDepth];
  logic [31:0] shared_mem [wstd_pkg::SharedDepth];
  logic [31:0] dq_rd, sh_rd;
  logic        rd_shared;
  logic [wstd_pkg::WBits-1:0] vic;
  logic [wstd_pkg::WBits:0]   steps;
  wstd_pkg::out_item_t res;

  logic [wstd_pkg::PBits-1:0] own_fill, vic_fill;
  logic [wstd_pkg::WBits:0]   vic_inc;
  logic [wstd_pkg::WBits-1:0] vic_nxt;

  assign own_fill = bot[cur.worker] - top[cur.worker];
  assign vic_fill = bot[vic] - top[vic];
  assign vic_inc  = {1'b0, vic} + 1'b1;
  assign vic_nxt  = (vic_inc >= cur.nwork) ? '0 : vic_inc[wstd_pkg::WBits-1:0];

  assign cmd_take  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data  = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      shared_count <= '0;
      next_number <= 32'd1;
      for (int i = 0; i < wstd_pkg::MaxWorkers; i++) begin
        top[i] <= '0;
        bot[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur <= cmd;
            res <= '{status: cmd.status, source: wstd_pkg::SRC_NONE,
                     victim: '0, job_out: '0, job_number: '0};
            state <= cmd.answer_only ? S_OUT : S_READ;
          end
        end
        S_READ: begin
          // decide action using registered command
          state <= S_OUT;
          case (cur.op)
            wstd_pkg::OP_PUSH_DEQ: begin
              res.source <= wstd_pkg::SRC_OWN;
              if (own_fill[wstd_pkg::PBits-1]) begin
                res.status <= wstd_pkg::ST_FULL;
              end else begin
                bot[cur.worker] <= bot[cur.worker] + 1'b1;
                res.status <= wstd_pkg::ST_OK;
                res.job_number <= next_number;
                next_number <= next_number + 32'd1;
              end
            end
            wstd_pkg::OP_PUSH_SH: begin
              res.source <= wstd_pkg::SRC_SHARED;
              if (shared_count[wstd_pkg::CBits-1]) begin
                res.status <= wstd_pkg::ST_FULL;
              end else begin
                shared_count <= shared_count + 1'b1;
                res.status <= wstd_pkg::ST_OK;
                res.job_number <= next_number;
                next_number <= next_number + 32'd1;
              end
            end
            default: begin
              if (own_fill != '0) begin
                bot[cur.worker] <= bot[cur.worker] - 1'b1;
                res.status <= wstd_pkg::ST_OK;
                res.source <= wstd_pkg::SRC_OWN;
                rd_shared <= 1'b0;
                state <= S_DATA;
              end else if (shared_count != '0) begin
                shared_count <= shared_count - 1'b1;
                res.status <= wstd_pkg::ST_OK;
                res.source <= wstd_pkg::SRC_SHARED;
                rd_shared <= 1'b1;
                state <= S_DATA;
              end else begin
                vic <= ({1'b0, cur.worker} + 1'b1 >= cur.nwork) ? '0 : cur.worker + 1'b1;
                steps <= (wstd_pkg::WBits+1)'(1);
                state <= S_SCAN;
              end
            end
          endcase
        end
        S_SCAN: begin
          if (steps >= cur.nwork) begin
            state <= S_OUT;
          end else if (vic_fill != '0) begin
            top[vic] <= top[vic] + 1'b1;
            res.status <= wstd_pkg::ST_OK;
            res.source <= wstd_pkg::SRC_STOLEN;
            res.victim <= 3'(vic);
            rd_shared <= 1'b0;
            state <= S_DATA;
          end else begin
            vic <= vic_nxt;
            steps <= steps + 1'b1;
          end
        end
        S_DATA: begin
          res.job_out <= rd_shared ? sh_rd : dq_rd;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // memory ports: writes on push, reads registered for the data state
  always_ff @(posedge clk) begin
    if (state == S_READ && cur.op == wstd_pkg::OP_PUSH_DEQ && !own_fill[wstd_pkg::PBits-1])
      deque_mem[{cur.worker, bot[cur.worker][wstd_pkg::DBits-1:0]}] <= cur.token;
    if (state == S_READ && cur.op == wstd_pkg::OP_GET && own_fill != '0)
      dq_rd <= deque_mem[{cur.worker, wstd_pkg::DBits'(bot[cur.worker] - 1'b1)}];
    else if (state == S_SCAN)
      dq_rd <= deque_mem[{vic, top[vic][wstd_pkg::DBits-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (state == S_READ && cur.op == wstd_pkg::OP_PUSH_SH && !shared_count[wstd_pkg::CBits-1])
      shared_mem[shared_count[wstd_pkg::SBits-1:0]] <= cur.token;
    sh_rd <= shared_mem[wstd_pkg::SBits'(shared_count - 1'b1)];
  end

endmodule

// ===== rtl/work_stealing_task_dispatcher_unit.sv =====
// top level of the work-stealing task dispatcher
// pushes go from accept through the read and output states, own and shared gets add a data state,
// and a steal adds a scan state that checks victim deques in turn (up to active_workers - 1)
// the single back-end sequencer finishes one command before it takes the next;
// a two-entry command queue lets input beats be taken while a result waits
// rst is synchronous: pointers and counts clear, job numbers restart at 1, active_workers 1
module work_stealing_task_dispatcher_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  wstd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output wstd_pkg::out_item_t out_data
);

  logic cmd_valid, cmd_take;
  wstd_pkg::cmd_t cmd;

  wstd_front u_front (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
  );

  wstd_back u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule
